// ===== sv/fpn_pkg.sv =====
// fpn_pkg: shared types, constants and the base permutation table
// used by the noise datapath and the top level; no dependencies
package fpn_pkg;

    localparam int MaxOctaves = 8;
    localparam int FracBits   = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OCT,
        ST_RD_A,
        ST_RD_B,
        ST_RD_AA,
        ST_RD_AB,
        ST_RD_BA,
        ST_RD_BB,
        ST_RD_H,
        ST_WAIT_H,
        ST_LERP,
        ST_ACC,
        ST_NORM,
        ST_OUT
    } t_state;

    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] REG_OCT  = 2'd0;
    localparam logic [1:0] REG_PERS = 2'd1;
    localparam logic [1:0] REG_NORM = 2'd2;

    function automatic logic [7:0] base_perm(input logic [7:0] i);
        logic [7:0] t [256];
        t = '{
            8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
            8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
            8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
            8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
            8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
            8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
            8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
            8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
            8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
            8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
            8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
            8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
            8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
            8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
            8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
            8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
            8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
            8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
            8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
            8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
            8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
            8'd215,8'd61,8'd156,8'd180
        };
        return t[i];
    endfunction

    // gradient dot product, inputs signed Q16 in [-65536, 65535]
    function automatic logic signed [18:0] grad(input logic [3:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y,
                                                input logic signed [17:0] z);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(x) : 19'(y);
        v = (h < 4'd4) ? 19'(y) : ((h == 4'd12 || h == 4'd14) ? 19'(x) : 19'(z));
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// ===== sv/fpn_perm_ram.sv =====
// fpn_perm_ram: 256x8 permutation store, one write and one read port
// read data registered; no package dependency
module fpn_perm_ram (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [7:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_raddr,
    output logic [7:0] o_rdata
);
    logic [7:0] r_mem [256];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/fpn_fade.sv =====
// fpn_fade: quintic fade 6t^5-15t^4+10t^3 in Q16, three registered steps
// no package dependency
module fpn_fade (
    input  logic        i_clk,
    input  logic [15:0] i_t,
    output logic [16:0] o_f
);
    logic [31:0] r_t2;
    logic [15:0] r_t1;
    logic [15:0] r_t3;
    logic [33:0] r_q;
    logic [47:0] w_t3;
    logic [50:0] w_q;
    logic [50:0] w_f;

    assign w_t3 = r_t2 * r_t1;
    assign w_q  = 51'(r_t2) * 51'd6 + (51'd10 << 32) - (51'(r_t1) * 51'd15 << 16);
    assign w_f  = 51'(r_t3) * 51'(r_q);

    always_ff @(posedge i_clk) begin
        r_t1 <= i_t;
        r_t2 <= i_t * i_t;
        r_t3 <= w_t3[47:32];
        r_q  <= w_q[49:16];
        o_f  <= w_f[32:16];
    end
endmodule

// ===== sv/fractal_perlin_noise_3d_top.sv =====
// fractal_perlin_noise_3d_top: octave sequencer around one permutation ram
// uses fpn_pkg, fpn_perm_ram, fpn_fade
// next item taken once the result is registered and no earlier result is still held;
// throughput set by the single ram read port (14 dependent lookups per octave) and the
// lerp unit; load beats are written to the ram while idle
// reset restores registers and copies the base table into the ram, during which
// no item is taken
module fractal_perlin_noise_3d_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [23:0]        i_x_coord,
    input  logic [23:0]        i_y_coord,
    input  logic [23:0]        i_z_coord,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    fpn_pkg::t_state r_state, n_state;

    logic [3:0]  r_oct_cnt;
    logic [15:0] r_pers;
    logic [16:0] r_norm;
    logic        r_clr;
    logic [7:0]  r_clr_idx;
    logic [23:0] r_x, r_y, r_z;
    logic [3:0]  r_oct, r_noct;
    logic [16:0] r_amp;
    logic signed [24:0] r_sum;
    logic [7:0]  r_a, r_b, r_aa, r_ab, r_ba, r_bb;
    logic [3:0]  r_h [8];
    logic [3:0]  r_hi;
    logic [4:0]  r_step;
    logic signed [18:0] r_l [8];
    logic signed [42:0] r_prod;
    logic        r_ovalid;
    logic signed [15:0] r_out;

    logic [23:0] w_cx, w_cy, w_cz;
    logic [7:0]  w_xi, w_yi, w_zi;
    logic [15:0] w_fx, w_fy, w_fz;
    logic [16:0] w_u, w_v, w_w;
    logic [7:0]  w_raddr, w_rdata, w_base;
    logic        w_we;
    logic [7:0]  w_waddr, w_wdata;
    logic signed [17:0] w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;
    logic [16:0] w_t;
    logic [7:0]  w_hb;
    logic signed [18:0] w_la, w_lb;
    logic signed [37:0] w_lm;
    logic signed [18:0] w_lr;
    logic [32:0] w_ampn;
    logic signed [35:0] w_nm;
    logic signed [42:0] w_sn;
    logic signed [24:0] w_r;

    assign w_cx = r_x << r_oct;
    assign w_cy = r_y << r_oct;
    assign w_cz = r_z << r_oct;
    assign w_xi = w_cx[23:16];
    assign w_yi = w_cy[23:16];
    assign w_zi = w_cz[23:16];
    assign w_fx = w_cx[15:0];
    assign w_fy = w_cy[15:0];
    assign w_fz = w_cz[15:0];
    assign w_x0 = 18'($signed({2'b0, w_fx}));
    assign w_y0 = 18'($signed({2'b0, w_fy}));
    assign w_z0 = 18'($signed({2'b0, w_fz}));
    assign w_x1 = w_x0 - 18'sd65536;
    assign w_y1 = w_y0 - 18'sd65536;
    assign w_z1 = w_z0 - 18'sd65536;

    fpn_fade u_fx (.i_clk(i_clk), .i_t(w_fx), .o_f(w_u));
    fpn_fade u_fy (.i_clk(i_clk), .i_t(w_fy), .o_f(w_v));
    fpn_fade u_fz (.i_clk(i_clk), .i_t(w_fz), .o_f(w_w));

    assign o_ready     = (r_state == fpn_pkg::ST_IDLE) && !r_clr;
    assign o_cfg_ready = i_rst_n;
    assign o_valid       = r_ovalid;
    assign o_noise_value = r_out;

    assign w_base  = fpn_pkg::base_perm(r_clr_idx);
    assign w_we    = r_clr || (i_valid && o_ready && i_op == fpn_pkg::OP_LOAD);
    assign w_waddr = r_clr ? r_clr_idx : i_table_index;
    assign w_wdata = r_clr ? w_base : i_table_value;

    // read address sequence: xi, xi+1, a, a+1, b, b+1, then 8 corner hashes
    always_comb begin
        unique case (r_state)
            fpn_pkg::ST_OCT:   w_raddr = w_xi;
            fpn_pkg::ST_RD_A:  w_raddr = w_xi + 8'd1;
            fpn_pkg::ST_RD_B:  w_raddr = r_a;
            fpn_pkg::ST_RD_AA: w_raddr = r_a + 8'd1;
            fpn_pkg::ST_RD_AB: w_raddr = r_b;
            fpn_pkg::ST_RD_BA: w_raddr = r_b + 8'd1;
            fpn_pkg::ST_RD_H: begin
                unique case (r_hi[2:0])
                    3'd0: w_raddr = r_aa;
                    3'd1: w_raddr = r_ba;
                    3'd2: w_raddr = r_ab;
                    3'd3: w_raddr = r_bb;
                    3'd4: w_raddr = r_aa + 8'd1;
                    3'd5: w_raddr = r_ba + 8'd1;
                    3'd6: w_raddr = r_ab + 8'd1;
                    default: w_raddr = r_bb + 8'd1;
                endcase
            end
            default: w_raddr = r_aa;
        endcase
    end

    fpn_perm_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // hash that arrived this cycle belongs to corner r_hi-1
    assign w_hb = w_rdata;

    // lerp schedule: steps 0..3 x-lerps, 4..5 y, 6 z
    always_comb begin
        w_t  = w_u;
        w_la = r_l[0];
        w_lb = r_l[1];
        case (r_step)
            5'd0: begin w_la = r_l[0]; w_lb = r_l[1]; w_t = w_u; end
            5'd1: begin w_la = r_l[2]; w_lb = r_l[3]; w_t = w_u; end
            5'd2: begin w_la = r_l[4]; w_lb = r_l[5]; w_t = w_u; end
            5'd3: begin w_la = r_l[6]; w_lb = r_l[7]; w_t = w_u; end
            5'd4: begin w_la = r_l[0]; w_lb = r_l[1]; w_t = w_v; end
            5'd5: begin w_la = r_l[2]; w_lb = r_l[3]; w_t = w_v; end
            default: begin w_la = r_l[0]; w_lb = r_l[1]; w_t = w_w; end
        endcase
        w_lm = (38'(w_lb) - 38'(w_la)) * 38'($signed({1'b0, w_t}));
        w_lr = w_la + 19'(w_lm >>> 16);
    end

    assign w_ampn = r_amp * r_pers;
    assign w_nm   = 36'(r_l[0]) * $signed({1'b0, r_amp});
    assign w_sn   = 43'(r_sum) * $signed({1'b0, r_norm});
    assign w_r    = 25'(r_prod >>> 17);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpn_pkg::ST_IDLE:
                if (i_valid && o_ready && i_op == fpn_pkg::OP_EVAL) begin
                    n_state = (r_oct_cnt == 4'd0) ? fpn_pkg::ST_NORM : fpn_pkg::ST_OCT;
                end
            fpn_pkg::ST_OCT:    n_state = fpn_pkg::ST_RD_A;
            fpn_pkg::ST_RD_A:   n_state = fpn_pkg::ST_RD_B;
            fpn_pkg::ST_RD_B:   n_state = fpn_pkg::ST_RD_AA;
            fpn_pkg::ST_RD_AA:  n_state = fpn_pkg::ST_RD_AB;
            fpn_pkg::ST_RD_AB:  n_state = fpn_pkg::ST_RD_BA;
            fpn_pkg::ST_RD_BA:  n_state = fpn_pkg::ST_RD_BB;
            fpn_pkg::ST_RD_BB:  n_state = fpn_pkg::ST_RD_H;
            fpn_pkg::ST_RD_H:   if (r_hi == 4'd8) n_state = fpn_pkg::ST_WAIT_H;
            fpn_pkg::ST_WAIT_H: n_state = fpn_pkg::ST_LERP;
            fpn_pkg::ST_LERP:   if (r_step == 5'd6) n_state = fpn_pkg::ST_ACC;
            fpn_pkg::ST_ACC:
                n_state = (r_oct + 4'd1 == r_noct) ? fpn_pkg::ST_NORM : fpn_pkg::ST_OCT;
            fpn_pkg::ST_NORM:   n_state = fpn_pkg::ST_OUT;
            fpn_pkg::ST_OUT:    if (!r_ovalid) n_state = fpn_pkg::ST_IDLE;
            default:            n_state = fpn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fpn_pkg::ST_IDLE;
            r_oct_cnt <= 4'd1;
            r_pers    <= 16'd32768;
            r_norm    <= 17'd65536;
            r_clr     <= 1'b1;
            r_clr_idx <= 8'd0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + 8'd1;
                if (r_clr_idx == 8'd255) r_clr <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fpn_pkg::REG_OCT:  r_oct_cnt <= i_cfg_data[3:0];
                    fpn_pkg::REG_PERS: r_pers    <= i_cfg_data[15:0];
                    fpn_pkg::REG_NORM: r_norm    <= i_cfg_data;
                    default: ;
                endcase
            end
            // result register frees the sequencer once the previous beat is gone
            if (r_state == fpn_pkg::ST_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fpn_pkg::ST_IDLE: begin
                r_x    <= i_x_coord;
                r_y    <= i_y_coord;
                r_z    <= i_z_coord;
                r_oct  <= 4'd0;
                r_amp  <= 17'd65536;
                r_sum  <= '0;
                r_prod <= '0;
                r_noct <= (r_oct_cnt > 4'(fpn_pkg::MaxOctaves)) ?
                          4'(fpn_pkg::MaxOctaves) : r_oct_cnt;
            end
            fpn_pkg::ST_RD_A:  r_a <= w_rdata + w_yi;
            fpn_pkg::ST_RD_B:  r_b <= w_rdata + w_yi;
            fpn_pkg::ST_RD_AA: r_aa <= w_rdata + w_zi;
            fpn_pkg::ST_RD_AB: r_ab <= w_rdata + w_zi;
            fpn_pkg::ST_RD_BA: r_ba <= w_rdata + w_zi;
            fpn_pkg::ST_RD_BB: begin
                r_bb <= w_rdata + w_zi;
                r_hi <= 4'd0;
            end
            fpn_pkg::ST_RD_H: begin
                r_hi <= r_hi + 4'd1;
                if (r_hi != 4'd0) r_h[r_hi[2:0] - 3'd1] <= w_hb[3:0];
            end
            fpn_pkg::ST_WAIT_H: begin
                r_l[0] <= fpn_pkg::grad(r_h[0], w_x0, w_y0, w_z0);
                r_l[1] <= fpn_pkg::grad(r_h[1], w_x1, w_y0, w_z0);
                r_l[2] <= fpn_pkg::grad(r_h[2], w_x0, w_y1, w_z0);
                r_l[3] <= fpn_pkg::grad(r_h[3], w_x1, w_y1, w_z0);
                r_l[4] <= fpn_pkg::grad(r_h[4], w_x0, w_y0, w_z1);
                r_l[5] <= fpn_pkg::grad(r_h[5], w_x1, w_y0, w_z1);
                r_l[6] <= fpn_pkg::grad(r_h[6], w_x0, w_y1, w_z1);
                r_l[7] <= fpn_pkg::grad(r_h[7], w_x1, w_y1, w_z1);
                r_step <= 5'd0;
            end
            fpn_pkg::ST_LERP: begin
                r_step <= r_step + 5'd1;
                case (r_step)
                    5'd0: r_l[0] <= w_lr;
                    5'd1: r_l[1] <= w_lr;
                    5'd2: r_l[2] <= w_lr;
                    5'd3: r_l[3] <= w_lr;
                    5'd4: r_l[0] <= w_lr;
                    5'd5: r_l[1] <= w_lr;
                    default: r_l[0] <= w_lr;
                endcase
            end
            fpn_pkg::ST_ACC: begin
                r_sum <= r_sum + 25'(w_nm >>> 16);
                r_amp <= w_ampn[32:16];
                r_oct <= r_oct + 4'd1;
            end
            fpn_pkg::ST_NORM: r_prod <= w_sn;
            fpn_pkg::ST_OUT:
                if (!r_ovalid) begin
                    if (w_r > 25'sd32767)       r_out <= 16'sd32767;
                    else if (w_r < -25'sd32768) r_out <= -16'sd32768;
                    else                        r_out <= w_r[15:0];
                end
            default: ;
        endcase
    end
endmodule

// ===== verif/fractal_perlin_noise_3d_top_tb.sv =====
// fractal_perlin_noise_3d_top_tb: self-checking bench for the fractal noise top level
// depends on fpn_pkg and fractal_perlin_noise_3d_top; own noise predictor inside
module fractal_perlin_noise_3d_top_tb;

    localparam logic [1:0] RegUnused = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_op;
    logic [23:0]        i_x_coord;
    logic [23:0]        i_y_coord;
    logic [23:0]        i_z_coord;
    logic [7:0]         i_table_index;
    logic [7:0]         i_table_value;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_noise_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [16:0]        i_cfg_data;

    fractal_perlin_noise_3d_top uut (.*);

    typedef struct {
        logic        op;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic        known;
        logic [15:0] noise;
    } t_row;

    logic [7:0]  perm_copy [256];
    logic [3:0]  octaves_r;
    logic [15:0] persist_r;
    logic [16:0] recip_r;

    logic [15:0] noise_q[$];
    int          errors;
    int          results_seen;
    int          evals_sent;
    int          loads_sent;
    int          send_idle;
    int          recv_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("timeout at %0t", $time);
        $display("fractal_perlin_noise_3d_top verification failed");
        $finish;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fade_q16(longint t);
        longint t3;
        longint q;
        t3 = (t * t * t) >>> 32;
        q = (6 * t * t + (longint'(10) << 32) - ((15 * t) << 16)) >>> 16;
        return (t3 * q) >>> 16;
    endfunction

    function automatic longint mix_q16(longint t, longint a, longint b);
        return a + fshift((b - a) * t, 16);
    endfunction

    function automatic longint dot_grad(int hash, longint x, longint y, longint z);
        int     h;
        longint u;
        longint v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic int pl(int i);
        return perm_copy[i & 255];
    endfunction

    function automatic longint lattice_noise(logic [23:0] cx, logic [23:0] cy,
                                             logic [23:0] cz);
        int     xi, yi, zi, a, aa, ab, b, ba, bb;
        longint x, y, z, x1, y1, z1, u, v, w, l0, l1;
        xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
        x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
        x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
        u = fade_q16(x); v = fade_q16(y); w = fade_q16(z);
        a = pl(xi) + yi; aa = pl(a) + zi; ab = pl(a + 1) + zi;
        b = pl(xi + 1) + yi; ba = pl(b) + zi; bb = pl(b + 1) + zi;
        l0 = mix_q16(v, mix_q16(u, dot_grad(pl(aa), x, y, z), dot_grad(pl(ba), x1, y, z)),
                     mix_q16(u, dot_grad(pl(ab), x, y1, z), dot_grad(pl(bb), x1, y1, z)));
        l1 = mix_q16(v, mix_q16(u, dot_grad(pl(aa + 1), x, y, z1),
                                dot_grad(pl(ba + 1), x1, y, z1)),
                     mix_q16(u, dot_grad(pl(ab + 1), x, y1, z1),
                             dot_grad(pl(bb + 1), x1, y1, z1)));
        return mix_q16(w, l0, l1);
    endfunction

    function automatic logic [15:0] fractal_noise(logic [23:0] x, logic [23:0] y,
                                                  logic [23:0] z);
        int     n;
        longint amp, sum, r;
        n = (octaves_r > fpn_pkg::MaxOctaves) ? fpn_pkg::MaxOctaves : octaves_r;
        amp = 65536;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            sum += fshift(lattice_noise(x << i, y << i, z << i) * amp, 16);
            amp = (amp * persist_r) >>> 16;
        end
        r = fshift(sum * longint'(recip_r), 17);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic set_idle(int s, int r);
        send_idle = s;
        recv_idle = r;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        // a trailing load is already in the ram once its beat is accepted
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            fpn_pkg::REG_OCT:  octaves_r = data[3:0];
            fpn_pkg::REG_PERS: persist_r = data[15:0];
            fpn_pkg::REG_NORM: recip_r   = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // valid stays up across back-to-back beats and drops only while idling
    task automatic send_item(t_row r);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= r.op;
        i_x_coord     <= r.x;
        i_y_coord     <= r.y;
        i_z_coord     <= r.z;
        i_table_index <= r.idx;
        i_table_value <= r.val;
        do @(posedge i_clk); while (!o_ready);
        if (r.op == fpn_pkg::OP_LOAD) begin
            perm_copy[r.idx] = r.val;
            loads_sent++;
        end else begin
            if (r.known && r.noise != fractal_noise(r.x, r.y, r.z))
                $display("%0t table row disagrees with predictor", $time);
            noise_q.push_back(r.known ? r.noise : fractal_noise(r.x, r.y, r.z));
            evals_sent++;
        end
    endtask

    function automatic t_row eval_row(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        t_row r;
        r = '{fpn_pkg::OP_EVAL, x, y, z, 8'($urandom), 8'($urandom), 1'b0, 16'd0};
        return r;
    endfunction

    function automatic t_row rand_eval();
        logic [23:0] c [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(5))
                0: c[k] = 24'hFFFFFF;
                1: c[k] = {8'($urandom), 16'd0};
                2: c[k] = {8'hFF, 16'($urandom)};
                default: c[k] = 24'($urandom);
            endcase
        end
        return eval_row(c[0], c[1], c[2]);
    endfunction

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (noise_q.size() == 0) begin
                    $display("%0t unexpected beat, expected none, actual %0d", $time,
                             o_noise_value);
                    errors++;
                end else begin
                    if (o_noise_value !== noise_q[0]) begin
                        $display("%0t noise_value expected %0d actual %0d", $time,
                                 $signed(noise_q[0]), o_noise_value);
                        errors++;
                    end
                    void'(noise_q.pop_front());
                    results_seen++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        t_row rows [$];
        int   phase;
        errors = 0; results_seen = 0; evals_sent = 0; loads_sent = 0;
        set_idle(0, 0);
        i_rst_n = 1'b0; i_valid = 1'b0; i_op = fpn_pkg::OP_EVAL;
        i_x_coord = '0; i_y_coord = '0; i_z_coord = '0;
        i_table_index = '0; i_table_value = '0;
        i_cfg_valid = 1'b0; i_cfg_index = fpn_pkg::REG_OCT; i_cfg_data = '0;
        for (int i = 0; i < 256; i++) perm_copy[i] = fpn_pkg::base_perm(8'(i));
        octaves_r = 4'd1; persist_r = 16'd32768; recip_r = 17'd65536;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lattice points give noise zero, so their results are read off directly
        rows.push_back('{fpn_pkg::OP_EVAL, 24'h000000, 24'h000000, 24'h000000,
                         8'hFF, 8'hFF, 1'b1, 16'd0});
        rows.push_back('{fpn_pkg::OP_EVAL, 24'hFF0000, 24'hFF0000, 24'hFF0000,
                         8'h00, 8'h00, 1'b1, 16'd0});
        rows.push_back(eval_row(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        rows.push_back(eval_row(24'h008000, 24'h008000, 24'h008000));
        rows.push_back(eval_row(24'h00FFFF, 24'h000001, 24'h7F8000));
        rows.push_back(eval_row(24'h123456, 24'hABCDEF, 24'h00FFFF));
        rows.push_back('{fpn_pkg::OP_LOAD, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                         8'd0, 8'd255, 1'b0, 16'd0});
        rows.push_back('{fpn_pkg::OP_LOAD, 24'h000000, 24'h000000, 24'h000000,
                         8'd255, 8'd0, 1'b0, 16'd0});
        rows.push_back(eval_row(24'hFF8000, 24'hFF4000, 24'h00C000));
        rows.push_back(eval_row(24'h004000, 24'h00C000, 24'hFF2000));
        foreach (rows[i]) send_item(rows[i]);
        drain();

        write_reg(fpn_pkg::REG_OCT, 17'd0);
        send_item('{fpn_pkg::OP_EVAL, 24'h123456, 24'h654321, 24'hABCDEF,
                    8'h0, 8'h0, 1'b1, 16'd0});
        drain();
        write_reg(fpn_pkg::REG_OCT, 17'h1FFFF);
        write_reg(fpn_pkg::REG_PERS, 17'h1FFFF);
        write_reg(fpn_pkg::REG_NORM, 17'h1FFFF);
        write_reg(RegUnused, 17'h1FFFF);
        send_item(eval_row(24'h4321AB, 24'h00FFFF, 24'h818181));
        send_item(eval_row(24'h7FFFFF, 24'h800000, 24'h0A0A0A));
        drain();
        write_reg(fpn_pkg::REG_NORM, 17'd0);
        send_item(eval_row(24'h4321AB, 24'h00FFFF, 24'h818181));
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_idle(0, 0);
                1: set_idle(53, 0);
                2: set_idle(0, 53);
                default: set_idle(21, 21);
            endcase
            write_reg(fpn_pkg::REG_OCT,
                      17'(phase == 7 ? 8 : (phase == 6 ? 15 : $urandom_range(1, 4))));
            write_reg(fpn_pkg::REG_PERS, 17'(phase == 5 ? 0 : $urandom_range(65535)));
            write_reg(fpn_pkg::REG_NORM, 17'(phase == 4 ? 65536 : $urandom_range(65536)));
            for (int n = 0; n < 165; n++) begin
                if ($urandom_range(9) == 0)
                    send_item('{fpn_pkg::OP_LOAD, 24'($urandom), 24'($urandom),
                                24'($urandom), 8'($urandom), 8'($urandom), 1'b0, 16'd0});
                else
                    send_item(rand_eval());
                if (n == 80) drain();
            end
            drain();
        end

        $display("%0d evaluations and %0d table loads, %0d results checked", evals_sent,
                 loads_sent, results_seen);
        $display("octave counts 0..15, persistence and reciprocal extremes, mixed stalls");
        if (errors == 0 && noise_q.size() == 0)
            $display("fractal_perlin_noise_3d_top verification clean");
        else
            $display("fractal_perlin_noise_3d_top verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/fpn_pkg.sv
sv/fpn_perm_ram.sv
sv/fpn_fade.sv
sv/fractal_perlin_noise_3d_top.sv
verif/fractal_perlin_noise_3d_top_tb.sv
